// ----- design/bmhpq_pkg.sv -----
// shared types and constants for the binary max-heap priority queue
`default_nettype none

package bmhpq_pkg;

    // fixed field widths
    localparam int CAP_W   = 7;
    localparam int COUNT_W = 7;
    localparam int DATA_W  = 32;

    // capacity after reset
    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    // operation codes
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // result status codes
    localparam logic [1:0] STATUS_DONE  = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    // input word
    typedef struct packed {
        logic                     op;
        logic signed [DATA_W-1:0] item_value;
        logic signed [DATA_W-1:0] item_priority;
    } t_in_word;

    // result word
    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] top_value;
        logic                     top_valid;
        logic [COUNT_W-1:0]       entry_count;
    } t_out_word;

    // one heap entry as stored
    typedef struct packed {
        logic signed [DATA_W-1:0] prio;
        logic signed [DATA_W-1:0] val;
    } t_entry;

    // controller to datapath commands
    typedef struct packed {
        logic       ld_new;
        logic       pop_start;
        logic       ld_cur;
        logic       rd_parent;
        logic       rd_left;
        logic       rd_right;
        logic       ld_left;
        logic       wr_up;
        logic       wr_cur;
        logic       wr_down;
        logic       out_load;
        logic [1:0] status;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic full;
        logic empty;
        logic idx_zero;
        logic up_gt;
        logic no_left;
        logic has_right;
        logic down_gt;
    } t_stat;

endpackage

`default_nettype wire

// ----- design/bmhpq_ctrl.sv -----
// controller state machine sequencing push sift-up and pop sift-down
`default_nettype none

module bmhpq_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    input  wire               i_op,
    input  wire               i_out_free,
    input  bmhpq_pkg::t_stat  i_stat,
    output logic              o_in_ready,
    output bmhpq_pkg::t_cmd   o_cmd
);

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_PUSH_UP  = 9'b000000010,
        S_PUSH_CMP = 9'b000000100,
        S_POP_LOAD = 9'b000001000,
        S_POP_DOWN = 9'b000010000,
        S_POP_LEFT = 9'b000100000,
        S_POP_CMP  = 9'b001000000,
        S_FINISH   = 9'b010000000,
        S_SPARE    = 9'b100000000
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_status, n_status;
    logic       accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    // next state and commands
    always_comb begin
        n_state  = r_state;
        n_status = r_status;
        o_cmd    = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_op == bmhpq_pkg::OP_PUSH) begin
                        if (i_stat.full) begin
                            n_status = bmhpq_pkg::STATUS_FULL;
                            n_state  = S_FINISH;
                        end else begin
                            n_status     = bmhpq_pkg::STATUS_DONE;
                            o_cmd.ld_new = 1'b1;
                            n_state      = S_PUSH_UP;
                        end
                    end else begin
                        if (i_stat.empty) begin
                            n_status = bmhpq_pkg::STATUS_EMPTY;
                            n_state  = S_FINISH;
                        end else begin
                            n_status        = bmhpq_pkg::STATUS_DONE;
                            o_cmd.pop_start = 1'b1;
                            n_state         = S_POP_LOAD;
                        end
                    end
                end
            end
            S_PUSH_UP: begin
                if (i_stat.idx_zero) begin
                    o_cmd.wr_cur = 1'b1;
                    n_state      = S_FINISH;
                end else begin
                    o_cmd.rd_parent = 1'b1;
                    n_state         = S_PUSH_CMP;
                end
            end
            S_PUSH_CMP: begin
                if (i_stat.up_gt) begin
                    o_cmd.wr_up = 1'b1;
                    n_state     = S_PUSH_UP;
                end else begin
                    o_cmd.wr_cur = 1'b1;
                    n_state      = S_FINISH;
                end
            end
            S_POP_LOAD: begin
                o_cmd.ld_cur = 1'b1;
                n_state      = S_POP_DOWN;
            end
            S_POP_DOWN: begin
                if (i_stat.no_left) begin
                    o_cmd.wr_cur = 1'b1;
                    n_state      = S_FINISH;
                end else begin
                    o_cmd.rd_left = 1'b1;
                    n_state       = S_POP_LEFT;
                end
            end
            S_POP_LEFT: begin
                o_cmd.ld_left  = 1'b1;
                o_cmd.rd_right = i_stat.has_right;
                n_state        = S_POP_CMP;
            end
            S_POP_CMP: begin
                if (i_stat.down_gt) begin
                    o_cmd.wr_down = 1'b1;
                    n_state       = S_POP_DOWN;
                end else begin
                    o_cmd.wr_cur = 1'b1;
                    n_state      = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        o_cmd.status = n_status;
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_status <= bmhpq_pkg::STATUS_DONE;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
        end
    end

endmodule

`default_nettype wire

// ----- design/bmhpq_dp.sv -----
// datapath: entry memory, fill count, capacity, sift registers and compares
`default_nettype none

module bmhpq_dp #(
    parameter int DEPTH = 64
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_we,
    input  wire  [bmhpq_pkg::CAP_W-1:0]         i_cfg_wdata,
    input  bmhpq_pkg::t_in_word                 i_in_word,
    input  bmhpq_pkg::t_cmd                     i_cmd,
    output bmhpq_pkg::t_stat                    o_stat,
    output bmhpq_pkg::t_out_word                o_result
);

    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int CXW   = AW + 2;
    localparam int CAP_W = bmhpq_pkg::CAP_W;
    localparam int CNT_W = bmhpq_pkg::COUNT_W;
    localparam int KW    = (CW > CAP_W) ? CW : CAP_W;

    bmhpq_pkg::t_entry mem [DEPTH];

    logic [CAP_W-1:0]          r_cap;
    logic [CW-1:0]             r_fill;
    logic [AW-1:0]             r_idx;
    bmhpq_pkg::t_entry         r_cur;
    bmhpq_pkg::t_entry         r_left;
    bmhpq_pkg::t_entry         r_rdata;
    logic signed [bmhpq_pkg::DATA_W-1:0] r_root_val;

    logic [CW-1:0]             fill_m1;
    logic [AW-1:0]             parent_idx;
    logic [CXW-1:0]            child_l;
    logic [CXW-1:0]            child_r;
    logic                      has_right;
    logic                      sel_right;
    bmhpq_pkg::t_entry         best;
    logic [AW-1:0]             best_idx;
    logic                      rd_en;
    logic [AW-1:0]             rd_addr;
    logic                      wr_en;
    bmhpq_pkg::t_entry         wr_data;

    // tree index arithmetic
    assign fill_m1    = r_fill - CW'(1);
    assign parent_idx = AW'((r_idx - AW'(1)) >> 1);
    assign child_l    = CXW'({r_idx, 1'b1});
    assign child_r    = child_l + CXW'(1);
    assign has_right  = child_r < CXW'(r_fill);

    // larger child, right only when strictly greater
    assign sel_right = has_right && ($signed(r_rdata.prio) > $signed(r_left.prio));
    assign best      = sel_right ? r_rdata : r_left;
    assign best_idx  = sel_right ? child_r[AW-1:0] : child_l[AW-1:0];

    // status to controller
    assign o_stat.full      = (KW'(r_fill) >= KW'(r_cap)) || (r_fill >= CW'(DEPTH));
    assign o_stat.empty     = (r_fill == '0);
    assign o_stat.idx_zero  = (r_idx == '0);
    assign o_stat.up_gt     = $signed(r_cur.prio) > $signed(r_rdata.prio);
    assign o_stat.no_left   = child_l >= CXW'(r_fill);
    assign o_stat.has_right = has_right;
    assign o_stat.down_gt   = $signed(best.prio) > $signed(r_cur.prio);

    // memory read address select
    always_comb begin
        rd_en   = i_cmd.pop_start || i_cmd.rd_parent || i_cmd.rd_left || i_cmd.rd_right;
        rd_addr = parent_idx;
        if (i_cmd.pop_start) begin
            rd_addr = fill_m1[AW-1:0];
        end else if (i_cmd.rd_left) begin
            rd_addr = child_l[AW-1:0];
        end else if (i_cmd.rd_right) begin
            rd_addr = child_r[AW-1:0];
        end
    end

    // memory write data select, always at the current index
    always_comb begin
        wr_en   = i_cmd.wr_up || i_cmd.wr_cur || i_cmd.wr_down;
        wr_data = best;
        if (i_cmd.wr_cur) begin
            wr_data = r_cur;
        end else if (i_cmd.wr_up) begin
            wr_data = r_rdata;
        end
    end

    // entry memory with registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_idx] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    // root value copy, follows every write to the root slot
    always_ff @(posedge i_clk) begin
        if (wr_en && (r_idx == '0)) begin
            r_root_val <= wr_data.val;
        end
    end

    // sift registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_new) begin
            r_cur.prio <= i_in_word.item_priority;
            r_cur.val  <= i_in_word.item_value;
            r_idx      <= r_fill[AW-1:0];
        end else if (i_cmd.pop_start) begin
            r_idx <= '0;
        end else if (i_cmd.wr_up) begin
            r_idx <= parent_idx;
        end else if (i_cmd.wr_down) begin
            r_idx <= best_idx;
        end
        if (i_cmd.ld_cur) begin
            r_cur <= r_rdata;
        end
        if (i_cmd.ld_left) begin
            r_left <= r_rdata;
        end
    end

    // fill count and capacity
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_cap  <= bmhpq_pkg::CAP_RESET;
        end else begin
            if (i_cmd.ld_new) begin
                r_fill <= r_fill + CW'(1);
            end else if (i_cmd.pop_start) begin
                r_fill <= fill_m1;
            end
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
        end
    end

    // result word
    assign o_result.status      = i_cmd.status;
    assign o_result.top_valid   = (r_fill != '0);
    assign o_result.top_value   = (r_fill != '0) ? r_root_val : '0;
    assign o_result.entry_count = CNT_W'(r_fill);

endmodule

`default_nettype wire

// ----- design/binary_max_heap_priority_queue.sv -----
// top level of the binary max-heap priority queue
//
//  channel | dir | handshake                      | word
//  --------+-----+--------------------------------+-------------------------------
//  in      | in  | i_in_valid / o_in_ready        | i_in_word  (op, value, prio)
//  out     | out | o_out_valid / i_out_ready      | o_out_word (status, top, count)
//  cfg     | in  | i_cfg_we, no wait              | i_cfg_wdata (capacity)
//
// one word at a time; the single-port entry memory sets the pace
// push and pop each run longer for every level the entry moves
// refused push or pop goes straight to the result; a new word is taken the cycle after the result loads
// a result waits in the output register; the next word is taken meanwhile
// synchronous reset empties the heap and sets capacity to 64, no clearing pass
`default_nettype none

module binary_max_heap_priority_queue #(
    parameter int DEPTH = 64
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_in_valid,
    output logic                         o_in_ready,
    input  bmhpq_pkg::t_in_word          i_in_word,
    output logic                         o_out_valid,
    input  wire                          i_out_ready,
    output bmhpq_pkg::t_out_word         o_out_word,
    input  wire                          i_cfg_we,
    input  wire  [bmhpq_pkg::CAP_W-1:0]  i_cfg_wdata
);

    bmhpq_pkg::t_cmd      cmd;
    bmhpq_pkg::t_stat     stat;
    bmhpq_pkg::t_out_word result;
    bmhpq_pkg::t_out_word r_out_word;
    logic                 r_out_valid;
    logic                 out_free;

    assign out_free = !r_out_valid || i_out_ready;

    // controller
    bmhpq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_op       (i_in_word.op),
        .i_out_free (out_free),
        .i_stat     (stat),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    // datapath
    bmhpq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_word   (i_in_word),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_result    (result)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd.out_load) begin
            r_out_word <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

`ifndef NO_ASSERTIONS
    // an accepted word keeps the block busy for at least the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken again right after accept");

    // a result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("result loaded over a pending word");

    // root flag agrees with the count
    a_top_valid_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.top_valid == (o_out_word.entry_count != '0)))
        else $error("top_valid disagrees with entry_count");

    // an empty refusal reports an empty heap
    a_empty_refusal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_word.status == bmhpq_pkg::STATUS_EMPTY))
            |-> (!o_out_word.top_valid && (o_out_word.top_value == '0)))
        else $error("empty refusal with entries present");
`endif

endmodule

`default_nettype wire

// ----- test/binary_max_heap_priority_queue_tb.sv -----
// self-checking testbench for the binary max-heap priority queue
`timescale 1ns / 100ps

module binary_max_heap_priority_queue_tb;

    localparam int DEPTH       = 64;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int PHASE_WORDS = 105;
    localparam int LONG_HOLD   = 300;
    localparam int DRAIN_WAIT  = 40;

    // expected heap contents and the results still owed by the block
    class heap_scoreboard;
        logic signed [bmhpq_pkg::DATA_W-1:0] key_mem[DEPTH];
        logic signed [bmhpq_pkg::DATA_W-1:0] payload_mem[DEPTH];
        int unsigned          entries_held;
        int unsigned          cap_setting;
        bmhpq_pkg::t_out_word pending_results[$];
        int unsigned          errors;

        function new();
            entries_held = 0;
            cap_setting  = bmhpq_pkg::CAP_RESET;
            errors       = 0;
        endfunction

        function void set_capacity(logic [bmhpq_pkg::CAP_W-1:0] cap);
            cap_setting = cap;
        endfunction

        function int unsigned capacity_limit();
            return (cap_setting > DEPTH) ? DEPTH : cap_setting;
        endfunction

        function int unsigned outstanding();
            return pending_results.size();
        endfunction

        function void swap_entries(int a, int b);
            logic signed [bmhpq_pkg::DATA_W-1:0] tmp;
            tmp            = key_mem[a];
            key_mem[a]     = key_mem[b];
            key_mem[b]     = tmp;
            tmp            = payload_mem[a];
            payload_mem[a] = payload_mem[b];
            payload_mem[b] = tmp;
        endfunction

        // apply one accepted word to the expected heap and queue its result
        function void note_word(bmhpq_pkg::t_in_word w);
            bmhpq_pkg::t_out_word res;
            int        idx;
            int        up;
            int        lchild;
            int        pick;
            res        = '0;
            res.status = bmhpq_pkg::STATUS_DONE;
            if (w.op == bmhpq_pkg::OP_PUSH) begin
                if (entries_held >= capacity_limit()) begin
                    res.status = bmhpq_pkg::STATUS_FULL;
                end else begin
                    idx              = entries_held;
                    key_mem[idx]     = w.item_priority;
                    payload_mem[idx] = w.item_value;
                    entries_held++;
                    // sift up on strictly greater key
                    while (idx > 0) begin
                        up = (idx - 1) / 2;
                        if (!(key_mem[idx] > key_mem[up])) break;
                        swap_entries(idx, up);
                        idx = up;
                    end
                end
            end else if (entries_held == 0) begin
                res.status = bmhpq_pkg::STATUS_EMPTY;
            end else begin
                entries_held--;
                key_mem[0]     = key_mem[entries_held];
                payload_mem[0] = payload_mem[entries_held];
                idx            = 0;
                // sift down, right child only when strictly greater than left
                while (1'b1) begin
                    lchild = 2 * idx + 1;
                    if (lchild >= entries_held) break;
                    pick = lchild;
                    if (lchild + 1 < entries_held && key_mem[lchild + 1] > key_mem[lchild])
                        pick = lchild + 1;
                    if (!(key_mem[pick] > key_mem[idx])) break;
                    swap_entries(idx, pick);
                    idx = pick;
                end
            end
            res.top_valid   = (entries_held > 0);
            res.top_value   = (entries_held > 0) ? payload_mem[0] : '0;
            res.entry_count = entries_held[bmhpq_pkg::COUNT_W-1:0];
            pending_results.push_back(res);
        endfunction

        // compare one result word with the oldest expectation
        function void check_result(bmhpq_pkg::t_out_word got);
            bmhpq_pkg::t_out_word want;
            if (pending_results.size() == 0) begin
                $display("%0t: result word with nothing expected, actual %p", $time, got);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (got.status !== want.status) begin
                $display("%0t: status expected %0d actual %0d",
                         $time, want.status, got.status);
                errors++;
            end
            if (got.top_value !== want.top_value) begin
                $display("%0t: top_value expected %0d actual %0d",
                         $time, want.top_value, got.top_value);
                errors++;
            end
            if (got.top_valid !== want.top_valid) begin
                $display("%0t: top_valid expected %0d actual %0d",
                         $time, want.top_valid, got.top_valid);
                errors++;
            end
            if (got.entry_count !== want.entry_count) begin
                $display("%0t: entry_count expected %0d actual %0d",
                         $time, want.entry_count, got.entry_count);
                errors++;
            end
        endfunction
    endclass

    logic                         clk       = 1'b0;
    logic                         rst_n     = 1'b0;
    logic                         in_valid  = 1'b0;
    logic                         in_ready;
    bmhpq_pkg::t_in_word          in_word   = '0;
    logic                         out_valid;
    logic                         out_ready = 1'b0;
    bmhpq_pkg::t_out_word         out_word;
    logic                         cfg_we    = 1'b0;
    logic [bmhpq_pkg::CAP_W-1:0]  cfg_wdata = '0;

    heap_scoreboard sb = new();

    int tx_idle_pct   = 0;
    int rx_idle_pct   = 0;
    int rx_stall_left = 0;
    int rx_draw       = 0;
    int hold_requests = 0;
    int holds_done    = 0;
    int cycle_count   = 0;

    binary_max_heap_priority_queue #(
        .DEPTH (DEPTH)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    // 2 ns clock
    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // run limit
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // result side ready: random stalls, plus a long hold-off on request
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready     <= 1'b0;
            rx_stall_left <= 0;
        end else if (rx_stall_left > 0) begin
            out_ready     <= 1'b0;
            rx_stall_left <= rx_stall_left - 1;
        end else if (holds_done != hold_requests) begin
            out_ready     <= 1'b0;
            rx_stall_left <= LONG_HOLD - 1;
            holds_done    <= holds_done + 1;
        end else begin
            rx_draw = $urandom_range(0, 99);
            if (rx_draw < 2) begin
                out_ready     <= 1'b0;
                rx_stall_left <= $urandom_range(15, 60);
            end else if (rx_draw < 2 + rx_idle_pct) begin
                out_ready     <= 1'b0;
                rx_stall_left <= $urandom_range(0, 2);
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // check every accepted result word
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) sb.check_result(out_word);
    end

    function automatic int next_gap();
        int draw;
        draw = $urandom_range(0, 99);
        if (draw < tx_idle_pct) return $urandom_range(1, 3);
        if (draw < tx_idle_pct + 2) return $urandom_range(15, 60);
        return 0;
    endfunction

    function automatic bmhpq_pkg::t_in_word make_word(
        logic op,
        logic signed [bmhpq_pkg::DATA_W-1:0] value,
        logic signed [bmhpq_pkg::DATA_W-1:0] key);
        bmhpq_pkg::t_in_word w;
        w.op            = op;
        w.item_value    = value;
        w.item_priority = key;
        return w;
    endfunction

    // keys: mostly narrow ranges so ties are common, some full range and extremes
    function automatic logic signed [bmhpq_pkg::DATA_W-1:0] random_key();
        int draw;
        int k;
        draw = $urandom_range(0, 99);
        if (draw < 40) begin
            k = $urandom_range(0, 8);
            return k - 4;
        end
        if (draw < 70) begin
            k = $urandom_range(0, 2000);
            return k - 1000;
        end
        if (draw < 90) return $urandom;
        case ($urandom_range(0, 3))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return 32'sh0;
            default: return -32'sd1;
        endcase
    endfunction

    // offer one word after an optional gap and hold it until accepted
    task automatic send_word(input bmhpq_pkg::t_in_word w, input int gap);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge clk); while (!in_ready);
        sb.note_word(w);
    endtask

    task automatic push_entry(input logic signed [bmhpq_pkg::DATA_W-1:0] value,
                              input logic signed [bmhpq_pkg::DATA_W-1:0] key);
        send_word(make_word(bmhpq_pkg::OP_PUSH, value, key), next_gap());
    endtask

    task automatic pop_entry();
        send_word(make_word(bmhpq_pkg::OP_POP, $urandom, $urandom), next_gap());
    endtask

    // stop offering and wait for every owed result word
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.outstanding() != 0);
    endtask

    // capacity write, only while the block is idle
    task automatic write_capacity(input logic [bmhpq_pkg::CAP_W-1:0] cap);
        cfg_we    <= 1'b1;
        cfg_wdata <= cap;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.set_capacity(cap);
    endtask

    initial begin
        int                   phase_caps[9];
        int                   cap;
        int                   target;
        bit                   filling;
        int                   push_pct;
        bmhpq_pkg::t_in_word  w;

        phase_caps = '{127, 64, 65, 0, 1, 0, 100, 3, 64};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset capacity, empty pop, extreme values and keys, ties
        pop_entry();
        push_entry(32'sh7fff_ffff, 32'sh0);
        push_entry(32'sh8000_0000, 32'sh7fff_ffff);
        push_entry(-32'sd1, 32'sh8000_0000);
        push_entry(32'sh0, 32'sh7fff_ffff);
        push_entry(32'sd5, 32'sd1);
        repeat (6) pop_entry();
        drain();

        // directed: small capacity, refused push when full
        write_capacity(7'd3);
        push_entry(32'sd11, 32'sd2);
        push_entry(32'sd12, 32'sd2);
        push_entry(32'sd13, 32'sd3);
        push_entry(32'sd14, 32'sd9);
        pop_entry();
        push_entry(32'sd15, -32'sd7);
        push_entry(32'sd16, 32'sd100);
        drain();

        // directed: zero capacity, then capacity below the fill level
        write_capacity(7'd0);
        push_entry(32'sd17, 32'sd1);
        pop_entry();
        drain();
        write_capacity(7'd1);
        push_entry(32'sd18, 32'sd50);
        pop_entry();
        push_entry(32'sd19, 32'sd60);
        push_entry(32'sd20, 32'sd70);
        drain();

        // random phases over a spread of capacities
        for (int ph = 0; ph < 9; ph++) begin
            cap = (ph == 5) ? $urandom_range(2, 20) : phase_caps[ph];
            write_capacity(cap[bmhpq_pkg::CAP_W-1:0]);
            tx_idle_pct = (ph % 3) * 30;
            rx_idle_pct = ((ph + 1) % 3) * 25;
            if (ph == 0) begin
                // result side holds off while words keep coming
                tx_idle_pct   = 0;
                hold_requests = hold_requests + 1;
            end
            filling = 1'b1;
            target  = sb.capacity_limit();
            for (int n = 0; n < PHASE_WORDS; n++) begin
                // fill toward a target, then mostly drain back to empty
                if (filling && sb.entries_held >= target) begin
                    filling = 1'b0;
                end else if (!filling && sb.entries_held == 0) begin
                    filling = 1'b1;
                    target  = ($urandom_range(0, 1) != 0) ? sb.capacity_limit()
                                                          : $urandom_range(1, DEPTH);
                end
                push_pct = filling ? 80 : 20;
                if ($urandom_range(0, 99) < push_pct)
                    w = make_word(bmhpq_pkg::OP_PUSH, $urandom, random_key());
                else
                    w = make_word(bmhpq_pkg::OP_POP, $urandom, $urandom);
                send_word(w, next_gap());
                // sender pause until the block has caught up
                if (n == PHASE_WORDS / 2) drain();
            end
            drain();
        end

        repeat (DRAIN_WAIT) @(posedge clk);
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
